/* rtl/ltudst_pkg.sv */
// ----------------------------------------------------------------------------
// ltudst_pkg
// Shared types, constants and tables for the local time to UTC converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ltudst_pkg;

  localparam int YEAR_W  = 14;
  localparam int UTC_W   = 39;
  localparam int OFS_W   = 17;
  localparam int TOD_W   = 17;
  localparam int BASE_W  = 24;
  localparam int RDAY_W  = 10;
  localparam int RSEC_W  = 27;

  localparam int YEARS_PER_ERA = 400;
  localparam int DAYS_PER_ERA  = 146097;
  localparam int EPOCH_SHIFT   = 719468;
  localparam int SEC_PER_DAY   = 86400;
  localparam int SEC_PER_HOUR  = 3600;
  localparam int SEC_PER_MIN   = 60;

  // floor(y / 400) = (y * 5243) >> 21 for y < 43690
  localparam int ERA_RECIP = 5243;
  // floor(v / 7) = (v * 586) >> 12 for v < 682
  localparam int WD_RECIP  = 586;

  // day offsets from March 1 (shifted year)
  localparam int DOY_MAR31 = 30;
  localparam int DOY_OCT31 = 244;
  localparam int DOY_NOV1  = 245;

  typedef enum logic [1:0] {
    RULE_NONE = 2'd0,
    RULE_US   = 2'd1,
    RULE_EU   = 2'd2,
    RULE_UK   = 2'd3
  } rule_t;

  typedef enum logic [0:0] {
    CFG_STD_OFFSET = 1'b0,
    CFG_DST_RULE   = 1'b1
  } cfg_idx_t;

  // date stage result: days of March 1 of the input year and the item's
  // day relative to it
  typedef struct packed {
    logic signed [BASE_W-1:0] base;
    logic signed [RDAY_W-1:0] rel_day;
    logic [TOD_W-1:0]         tod;
    logic [2:0]               wd_mar1;
  } days_t;

  typedef struct packed {
    logic [UTC_W-1:0] local_sec;
    logic             dst;
  } local_t;

  // (153 * mp + 2) / 5 with mp the month index of the March-based year
  function automatic logic [8:0] month_doy(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd13:   r = 9'd306;
      4'd14:   r = 9'd337;
      default: r = 9'd367;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/ltudst_days.sv */
// ----------------------------------------------------------------------------
// ltudst_days
// Four-stage civil date pipeline: era split, day-of-era, March 1 base day
// count, relative day and weekday of March 1.
// ----------------------------------------------------------------------------
`default_nettype none

module ltudst_days (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            in_vld,
  input  wire logic [ltudst_pkg::YEAR_W-1:0]   year,
  input  wire logic [3:0]                      month,
  input  wire logic [4:0]                      day,
  input  wire logic [4:0]                      hour,
  input  wire logic [5:0]                      minute,
  input  wire logic [5:0]                      second,
  output logic                                 out_vld,
  output ltudst_pkg::days_t                    out_days
);

  // stage 1
  logic                              v1_r;
  logic [ltudst_pkg::YEAR_W-1:0]     year1_r;
  logic [5:0]                        era1_r;
  logic [8:0]                        mdoy1_r;
  logic [4:0]                        day1_r;
  logic                              lowm1_r;
  logic [ltudst_pkg::TOD_W-1:0]      tod1_r;

  logic [26:0]                       eprod;
  logic [ltudst_pkg::TOD_W-1:0]      tod_nxt;

  assign eprod   = 27'(year) * 27'(ltudst_pkg::ERA_RECIP);
  assign tod_nxt = 17'(hour) * 17'(ltudst_pkg::SEC_PER_HOUR)
                 + 17'(minute) * 17'(ltudst_pkg::SEC_PER_MIN)
                 + 17'(second);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      year1_r <= year;
      era1_r  <= eprod[26:21];
      mdoy1_r <= ltudst_pkg::month_doy(month);
      day1_r  <= day;
      lowm1_r <= (month <= 4'd2);
      tod1_r  <= tod_nxt;
    end
  end

  // stage 2
  logic                              v2_r;
  logic [8:0]                        yoe2_r;
  logic [22:0]                       eraday2_r;
  logic signed [ltudst_pkg::RDAY_W-1:0] doyi2_r;
  logic                              lowm2_r;
  logic [ltudst_pkg::TOD_W-1:0]      tod2_r;

  logic [13:0]                       yoe_w;
  logic signed [ltudst_pkg::RDAY_W-1:0] doyi_w;

  assign yoe_w  = year1_r - 14'(era1_r) * 14'(ltudst_pkg::YEARS_PER_ERA);
  assign doyi_w = $signed({1'b0, mdoy1_r}) + $signed({5'b0, day1_r}) - 10'sd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yoe2_r    <= yoe_w[8:0];
      eraday2_r <= 23'(era1_r) * 23'(ltudst_pkg::DAYS_PER_ERA);
      doyi2_r   <= doyi_w;
      lowm2_r   <= lowm1_r;
      tod2_r    <= tod1_r;
    end
  end

  // stage 3
  logic                              v3_r;
  logic [8:0]                        vsum3_r;
  logic [17:0]                       doe3_r;
  logic                              leap3_r;
  logic [22:0]                       eraday3_r;
  logic signed [ltudst_pkg::RDAY_W-1:0] doyi3_r;
  logic                              lowm3_r;
  logic [ltudst_pkg::TOD_W-1:0]      tod3_r;

  logic [1:0]                        cent;
  logic [8:0]                        vsum_w;
  logic                              leap_w;

  always_comb begin
    if (yoe2_r >= 9'd300) begin
      cent = 2'd3;
    end else if (yoe2_r >= 9'd200) begin
      cent = 2'd2;
    end else if (yoe2_r >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
  end

  // yoe + yoe/4 - yoe/100; doe = 364*yoe + that
  assign vsum_w = yoe2_r + 9'(yoe2_r[8:2]) - 9'(cent);
  assign leap_w = (yoe2_r[1:0] == 2'b00) &&
                  !(yoe2_r inside {9'd100, 9'd200, 9'd300});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vsum3_r   <= vsum_w;
      doe3_r    <= 18'(yoe2_r) * 18'd364 + 18'(vsum_w);
      leap3_r   <= leap_w;
      eraday3_r <= eraday2_r;
      doyi3_r   <= doyi2_r;
      lowm3_r   <= lowm2_r;
      tod3_r    <= tod2_r;
    end
  end

  // stage 4
  logic                              v4_r;
  ltudst_pkg::days_t                 days4_r;

  logic signed [ltudst_pkg::BASE_W-1:0] base_w;
  logic [9:0]                        adj_w;
  logic [9:0]                        wsum;
  logic [19:0]                       wprod;
  logic [9:0]                        wrem;

  assign base_w = $signed({1'b0, eraday3_r}) + $signed({6'b0, doe3_r})
                - $signed(24'(ltudst_pkg::EPOCH_SHIFT));
  // Jan/Feb belong to the shifted year before: back off one full year
  assign adj_w  = lowm3_r ? (10'd365 + 10'(leap3_r)) : 10'd0;
  // era length is a whole number of weeks, so weekday follows from doe alone
  assign wsum   = 10'(vsum3_r) + 10'd3;
  assign wprod  = 20'(wsum) * 20'(ltudst_pkg::WD_RECIP);
  assign wrem   = wsum - 10'(wprod[18:12]) * 10'd7;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      days4_r.base    <= base_w;
      days4_r.rel_day <= doyi3_r - $signed(adj_w);
      days4_r.tod     <= tod3_r;
      days4_r.wd_mar1 <= wrem[2:0];
    end
  end

  assign out_vld  = v4_r;
  assign out_days = days4_r;

endmodule

`default_nettype wire

/* rtl/ltudst_dst.sv */
// ----------------------------------------------------------------------------
// ltudst_dst
// Two-stage daylight rule check and local seconds since the epoch.
// ----------------------------------------------------------------------------
`default_nettype none

module ltudst_dst (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire ltudst_pkg::rule_t   rule,
  input  wire logic                in_vld,
  input  wire ltudst_pkg::days_t   in_days,
  output logic                     out_vld,
  output ltudst_pkg::local_t       out_local
);

  // stage 5: transition instants relative to March 1, item seconds
  logic                                  v5_r;
  logic signed [ltudst_pkg::RSEC_W-1:0]  start5_r;
  logic signed [ltudst_pkg::RSEC_W-1:0]  end5_r;
  logic signed [ltudst_pkg::RSEC_W-1:0]  rel5_r;
  logic signed [ltudst_pkg::BASE_W-1:0]  days5_r;
  logic [ltudst_pkg::TOD_W-1:0]          tod5_r;

  logic [2:0] wd;
  logic [2:0] first_sun;
  logic [2:0] mar_last_wd;
  logic [2:0] oct_last_wd;
  logic [8:0] sdoy;
  logic [8:0] edoy;
  logic [1:0] sh;
  logic [1:0] eh;
  logic [ltudst_pkg::RSEC_W-1:0] start_w;
  logic [ltudst_pkg::RSEC_W-1:0] end_w;
  logic [ltudst_pkg::RSEC_W-1:0] rel_w;
  logic signed [ltudst_pkg::BASE_W-1:0] days_w;

  assign wd          = in_days.wd_mar1;
  assign first_sun   = (wd == 3'd0) ? 3'd0 : 3'd7 - wd;
  assign mar_last_wd = (wd >= 3'd5) ? wd - 3'd5 : wd + 3'd2;
  assign oct_last_wd = (wd == 3'd0) ? 3'd6 : wd - 3'd1;

  always_comb begin
    case (rule)
      ltudst_pkg::RULE_US: begin
        sdoy = 9'(first_sun) + 9'd7;
        edoy = 9'(ltudst_pkg::DOY_NOV1) + 9'(first_sun);
        sh   = 2'd2;
        eh   = 2'd2;
      end
      ltudst_pkg::RULE_EU: begin
        sdoy = 9'(ltudst_pkg::DOY_MAR31) - 9'(mar_last_wd);
        edoy = 9'(ltudst_pkg::DOY_OCT31) - 9'(oct_last_wd);
        sh   = 2'd2;
        eh   = 2'd3;
      end
      ltudst_pkg::RULE_UK: begin
        sdoy = 9'(ltudst_pkg::DOY_MAR31) - 9'(mar_last_wd);
        edoy = 9'(ltudst_pkg::DOY_OCT31) - 9'(oct_last_wd);
        sh   = 2'd1;
        eh   = 2'd2;
      end
      default: begin
        sdoy = 9'd0;
        edoy = 9'd0;
        sh   = 2'd0;
        eh   = 2'd0;
      end
    endcase
  end

  assign start_w = 27'(sdoy) * 27'(ltudst_pkg::SEC_PER_DAY)
                 + 27'(sh) * 27'(ltudst_pkg::SEC_PER_HOUR);
  assign end_w   = 27'(edoy) * 27'(ltudst_pkg::SEC_PER_DAY)
                 + 27'(eh) * 27'(ltudst_pkg::SEC_PER_HOUR);
  assign rel_w   = {{17{in_days.rel_day[9]}}, in_days.rel_day}
                 * 27'(ltudst_pkg::SEC_PER_DAY) + 27'(in_days.tod);
  assign days_w  = in_days.base + {{14{in_days.rel_day[9]}}, in_days.rel_day};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      start5_r <= $signed(start_w);
      end5_r   <= $signed(end_w);
      rel5_r   <= $signed(rel_w);
      days5_r  <= days_w;
      tod5_r   <= in_days.tod;
    end
  end

  // stage 6: window test and local seconds
  logic                 v6_r;
  ltudst_pkg::local_t   loc6_r;

  logic [40:0]          lprod;
  logic                 dst_w;

  assign lprod = {{17{days5_r[23]}}, days5_r} * 41'(ltudst_pkg::SEC_PER_DAY)
               + 41'(tod5_r);
  assign dst_w = (rule != ltudst_pkg::RULE_NONE) &&
                 (rel5_r >= start5_r) && (rel5_r < end5_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      loc6_r.local_sec <= lprod[ltudst_pkg::UTC_W-1:0];
      loc6_r.dst       <= dst_w;
    end
  end

  assign out_vld   = v6_r;
  assign out_local = loc6_r;

endmodule

`default_nettype wire

/* rtl/local_time_to_utc_dst.sv */
// ----------------------------------------------------------------------------
// local_time_to_utc_dst
// Local civil date and time to UTC seconds with a fixed daylight rule.
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_stall is low (year, month, day, hour,
// minute, second of local time) and returns one word per input: UTC seconds
// since 1970-01-01, the applied offset and a daylight flag. The seven
// register stages split the constant multiplies (era split, days-of-era,
// day-to-seconds) and the rule compare. A stall on the output freezes the
// whole pipe; nothing is dropped. Program standard_offset (index 0) and
// dst_rule (index 1: none, US, EU, UK) only while the pipe is empty.
// Out-of-range month or day values go through the date formula as is; the
// daylight window always uses the given year.
// ----------------------------------------------------------------------------
`default_nettype none

module local_time_to_utc_dst (
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [16:0]         cfg_wdata,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [13:0]         in_year,
  input  wire logic [3:0]          in_month,
  input  wire logic [4:0]          in_day,
  input  wire logic [4:0]          in_hour,
  input  wire logic [5:0]          in_minute,
  input  wire logic [5:0]          in_second,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [38:0]       out_utc_seconds,
  output logic signed [16:0]       out_offset_seconds,
  output logic                     out_dst_active
);

  // ---- configuration registers ----
  logic signed [ltudst_pkg::OFS_W-1:0] std_ofs_r;
  ltudst_pkg::rule_t                   rule_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      std_ofs_r <= '0;
      rule_r    <= ltudst_pkg::RULE_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        ltudst_pkg::CFG_STD_OFFSET: std_ofs_r <= $signed(cfg_wdata);
        ltudst_pkg::CFG_DST_RULE:   rule_r    <= ltudst_pkg::rule_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // ---- pipeline advance ----
  // Every stage moves when the output register is empty or being taken.
  logic out_valid_r;
  logic en;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---- stages 1-4: civil date to day counts ----
  logic              days_vld;
  ltudst_pkg::days_t days;

  ltudst_days u_days (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .year     (in_year),
    .month    (in_month),
    .day      (in_day),
    .hour     (in_hour),
    .minute   (in_minute),
    .second   (in_second),
    .out_vld  (days_vld),
    .out_days (days)
  );

  // ---- stages 5-6: daylight window and local seconds ----
  logic               loc_vld;
  ltudst_pkg::local_t loc;

  ltudst_dst u_dst (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .rule      (rule_r),
    .in_vld    (days_vld),
    .in_days   (days),
    .out_vld   (loc_vld),
    .out_local (loc)
  );

  // ---- stage 7: apply offset, output register ----
  // offset is formed at 18 bits so utc uses the exact sum; the offset field
  // keeps only its low 17 bits
  logic signed [17:0]       off_w;
  logic [ltudst_pkg::UTC_W-1:0] utc_w;
  logic [ltudst_pkg::UTC_W-1:0] utc_r;
  logic [16:0]              off_r;
  logic                     dst_r;

  assign off_w = {std_ofs_r[16], std_ofs_r}
               + (loc.dst ? $signed(18'(ltudst_pkg::SEC_PER_HOUR)) : 18'sd0);
  assign utc_w = loc.local_sec - {{21{off_w[17]}}, off_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= loc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      utc_r <= utc_w;
      off_r <= off_w[16:0];
      dst_r <= loc.dst;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_utc_seconds    = $signed(utc_r);
  assign out_offset_seconds = $signed(off_r);
  assign out_dst_active     = dst_r;

endmodule

`default_nettype wire

/* verif/tb_local_time_to_utc_dst.sv */
// ----------------------------------------------------------------------------
// tb_local_time_to_utc_dst
// Self-checking bench for the local time to UTC converter with daylight rules.
// ----------------------------------------------------------------------------
// Words go in through a valid/stall sender with random gaps. A built-in
// predictor computes UTC seconds, the applied offset and the daylight flag
// for each accepted word. A checker pops the oldest prediction for every
// accepted result and compares field by field. Directed tests cover the
// field extremes, the transition instants of each rule and an offset that
// wraps 17 bits. A random phase then walks through several zone settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_local_time_to_utc_dst;
  timeunit 1ns;
  timeprecision 1ps;

  import ltudst_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WORDS_PER_PHASE = 63;

  typedef struct {
    logic signed [UTC_W-1:0] utc;
    logic signed [OFS_W-1:0] ofs;
    logic                    dst;
  } utc_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [16:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [13:0]        in_year;
  logic [3:0]         in_month;
  logic [4:0]         in_day;
  logic [4:0]         in_hour;
  logic [5:0]         in_minute;
  logic [5:0]         in_second;
  logic               out_valid;
  logic               out_stall;
  logic signed [38:0] out_utc_seconds;
  logic signed [16:0] out_offset_seconds;
  logic               out_dst_active;

  // predictor's copy of the zone registers
  longint      zone_offset;
  rule_t       zone_rule;

  utc_result_t expected_utc[$];
  int          n_fail;
  int          n_sent;
  int          n_checked;
  int          n_zones;
  int          n_cycles;
  bit          in_gaps_on;
  bit          out_gaps_on;

  always #4 clk = ~clk;

  local_time_to_utc_dst u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_year            (in_year),
    .in_month           (in_month),
    .in_day             (in_day),
    .in_hour            (in_hour),
    .in_minute          (in_minute),
    .in_second          (in_second),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_utc_seconds    (out_utc_seconds),
    .out_offset_seconds (out_offset_seconds),
    .out_dst_active     (out_dst_active)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Day number since 1970-01-01, 400-year era method. Months outside 1..12
  // run through the same arithmetic with no clamp.
  function automatic longint day_count(longint y, longint m, longint d);
    longint era, yoe, doy, doe, mp;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * DAYS_PER_ERA + doe - EPOCH_SHIFT;
  endfunction

  // 0 is Sunday; 1970-01-01 was a Thursday
  function automatic longint day_of_week(longint y, longint m, longint d);
    longint r;
    r = (day_count(y, m, d) + 4) % 7;
    return (r < 0) ? r + 7 : r;
  endfunction

  function automatic longint sunday_nth(longint y, longint m, longint n);
    return 1 + ((7 - day_of_week(y, m, 1)) % 7) + (n - 1) * 7;
  endfunction

  // only March and October are asked for, both 31 days long
  function automatic longint sunday_last(longint y, longint m);
    return 31 - day_of_week(y, m, 31);
  endfunction

  function automatic longint switch_instant(longint y, longint m, longint d, longint h);
    return day_count(y, m, d) * SEC_PER_DAY + h * SEC_PER_HOUR;
  endfunction

  function automatic utc_result_t convert_to_utc(longint y, longint mo, longint d,
                                                 longint h, longint mi, longint s);
    utc_result_t r;
    longint      loc, t_on, t_off, ofs, diff, sh;
    bit          dst;
    loc = day_count(y, mo, d) * SEC_PER_DAY + h * SEC_PER_HOUR + mi * 60 + s;
    dst = 1'b0;
    case (zone_rule)
      RULE_US: begin
        t_on  = switch_instant(y, 3, sunday_nth(y, 3, 2), 2);
        t_off = switch_instant(y, 11, sunday_nth(y, 11, 1), 2);
        dst   = (loc >= t_on) && (loc < t_off);
      end
      RULE_EU, RULE_UK: begin
        sh    = (zone_rule == RULE_UK) ? 1 : 2;
        t_on  = switch_instant(y, 3, sunday_last(y, 3), sh);
        t_off = switch_instant(y, 10, sunday_last(y, 10), sh + 1);
        dst   = (loc >= t_on) && (loc < t_off);
      end
      default: dst = 1'b0;
    endcase
    // utc uses the full sum; the offset field keeps only its low 17 bits
    ofs   = zone_offset + (dst ? SEC_PER_HOUR : 0);
    diff  = loc - ofs;
    r.utc = diff[UTC_W-1:0];
    r.ofs = ofs[OFS_W-1:0];
    r.dst = dst;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared tasks
  // --------------------------------------------------------------------------

  // Sends one word; in_valid stays high afterwards so back-to-back words
  // never drop it. Returns at the accepting edge.
  task automatic send_word(input logic [13:0] y, input logic [3:0] mo,
                           input logic [4:0] d, input logic [4:0] h,
                           input logic [5:0] mi, input logic [5:0] s);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_year   <= y;
    in_month  <= mo;
    in_day    <= d;
    in_hour   <= h;
    in_minute <= mi;
    in_second <= s;
    do @(posedge clk); while (in_stall);
    expected_utc.push_back(convert_to_utc(y, mo, d, h, mi, s));
    n_sent++;
  endtask

  // Drop valid and let every pending result come out.
  task automatic drain_pipe;
    in_valid <= 1'b0;
    while (expected_utc.size() != 0) @(posedge clk);
  endtask

  // Writes both zone registers once the pipe is empty.
  task automatic set_zone(input logic signed [16:0] ofs, input rule_t rule);
    drain_pipe();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STD_OFFSET;
    cfg_wdata <= ofs;
    @(posedge clk);
    zone_offset = ofs;
    cfg_index <= CFG_DST_RULE;
    cfg_wdata <= {15'd0, rule};
    @(posedge clk);
    zone_rule = rule;
    cfg_we    <= 1'b0;
    n_zones++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // epoch, year 0, top of the range, all-ones fields, zero month/day,
  // leap day and months past December
  task automatic test_field_extremes;
    set_zone(17'sd0, RULE_NONE);
    send_word(14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_word(14'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_word(14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_word(14'd16383, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    send_word(14'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_word(14'd2000, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0);
    send_word(14'd2024, 4'd13, 5'd5, 5'd7, 6'd30, 6'd15);
    send_word(14'd2023, 4'd14, 5'd28, 5'd1, 6'd2, 6'd3);
  endtask

  // one second either side of the US spring and fall switches, then two summer noons
  task automatic test_us_rule;
    set_zone(-17'sd18000, RULE_US);
    send_word(14'd2024, 4'd3, 5'd10, 5'd1, 6'd59, 6'd59);
    send_word(14'd2024, 4'd3, 5'd10, 5'd2, 6'd0, 6'd0);
    send_word(14'd2024, 4'd11, 5'd3, 5'd1, 6'd59, 6'd59);
    send_word(14'd2024, 4'd11, 5'd3, 5'd2, 6'd0, 6'd0);
    send_word(14'd2024, 4'd7, 5'd4, 5'd12, 6'd0, 6'd0);
    send_word(14'd0, 4'd6, 5'd15, 5'd12, 6'd0, 6'd0);
  endtask

  task automatic test_eu_rule;
    set_zone(17'sd3600, RULE_EU);
    send_word(14'd2024, 4'd3, 5'd31, 5'd1, 6'd59, 6'd59);
    send_word(14'd2024, 4'd3, 5'd31, 5'd2, 6'd0, 6'd0);
    send_word(14'd2024, 4'd10, 5'd27, 5'd2, 6'd59, 6'd59);
    send_word(14'd2024, 4'd10, 5'd27, 5'd3, 6'd0, 6'd0);
  endtask

  task automatic test_uk_rule;
    set_zone(17'sd0, RULE_UK);
    send_word(14'd2024, 4'd3, 5'd31, 5'd0, 6'd59, 6'd59);
    send_word(14'd2024, 4'd3, 5'd31, 5'd1, 6'd0, 6'd0);
    send_word(14'd2024, 4'd10, 5'd27, 5'd1, 6'd59, 6'd59);
    send_word(14'd2024, 4'd10, 5'd27, 5'd2, 6'd0, 6'd0);
  endtask

  // summer offset past the 17-bit signed range, then the most negative one
  task automatic test_offset_wrap;
    set_zone(17'sd65535, RULE_EU);
    send_word(14'd2024, 4'd7, 5'd1, 5'd12, 6'd0, 6'd0);
    set_zone(-17'sd65536, RULE_US);
    send_word(14'd2024, 4'd7, 5'd1, 5'd12, 6'd0, 6'd0);
  endtask

  // Random words over several zone settings. Most are real dates, many in
  // the switch months near the switch hours; the rest use the whole width.
  task automatic test_random_mix;
    logic signed [16:0] ofs;
    logic [13:0]        y;
    logic [3:0]         mo;
    logic [4:0]         d, h;
    logic [5:0]         mi, s;
    int                 pick;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: ofs = -17'sd43200;
        1: ofs = 17'sd50400;
        2: ofs = -17'sd65536;
        3: ofs = 17'sd65535;
        4: ofs = -17'sd18000;
        5: ofs = 17'sd3600;
        6: ofs = 17'sd0;
        default: ofs = 17'(int'($urandom_range(0, 93600)) - 43200);
      endcase
      set_zone(ofs, rule_t'(phase % 4));
      // phase 0 runs flat out; the others mix gaps on each side
      in_gaps_on  = phase[0] | phase[2];
      out_gaps_on = phase[1] | phase[2];
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          y  = 14'($urandom); mo = 4'($urandom); d  = 5'($urandom);
          h  = 5'($urandom);  mi = 6'($urandom); s  = 6'($urandom);
        end else if (pick < 6) begin
          y  = 14'($urandom_range(1900, 2100));
          case ($urandom_range(0, 2))
            0:       mo = 4'd3;
            1:       mo = 4'd10;
            default: mo = 4'd11;
          endcase
          d  = 5'($urandom_range(1, 31));
          h  = 5'($urandom_range(0, 3));
          mi = ($urandom_range(0, 1) == 0) ? 6'd59 : 6'($urandom_range(0, 59));
          s  = ($urandom_range(0, 1) == 0) ? 6'd59 : 6'($urandom_range(0, 59));
        end else begin
          y  = 14'($urandom_range(1, 9999));
          mo = 4'($urandom_range(1, 12));
          d  = 5'($urandom_range(1, 28));
          h  = 5'($urandom_range(0, 23));
          mi = 6'($urandom_range(0, 59));
          s  = 6'($urandom_range(0, 59));
        end
        send_word(y, mo, d, h, mi, s);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall for a random count per word, then take one
  // --------------------------------------------------------------------------
  initial begin : out_side
    int n;
    out_stall <= 1'b0;
    forever begin
      n = out_gaps_on ? $urandom_range(0, 19) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Checker: every accepted result against the oldest prediction
  always @(posedge clk) begin : result_check
    utc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_utc.size() == 0) begin
        $error("result with nothing expected: utc %0d", out_utc_seconds);
        n_fail++;
      end else begin
        want = expected_utc.pop_front();
        n_checked++;
        if (out_utc_seconds !== want.utc) begin
          $error("utc_seconds: expected %0d, got %0d", want.utc, out_utc_seconds);
          n_fail++;
        end
        if (out_offset_seconds !== want.ofs) begin
          $error("offset_seconds: expected %0d, got %0d", want.ofs, out_offset_seconds);
          n_fail++;
        end
        if (out_dst_active !== want.dst) begin
          $error("dst_active: expected %0b, got %0b", want.dst, out_dst_active);
          n_fail++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    n_fail      = 0;
    n_sent      = 0;
    n_checked   = 0;
    n_zones     = 0;
    n_cycles    = 0;
    zone_offset = 0;
    zone_rule   = RULE_NONE;
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_STD_OFFSET;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_year   <= '0;
    in_month  <= '0;
    in_day    <= '0;
    in_hour   <= '0;
    in_minute <= '0;
    in_second <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_us_rule();
    test_eu_rule();
    test_uk_rule();
    test_offset_wrap();
    test_random_mix();

    drain_pipe();
    // a few more cycles to catch any stray result past the last one
    repeat (20) @(posedge clk);
    $display("sent %0d words, checked %0d results over %0d zone settings",
             n_sent, n_checked, n_zones);
    $display("rules none/US/EU/UK, offsets at both 17-bit limits, gaps on both sides");
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
